// ===== rtl/websocket_client_frame_deframer_defines.svh =====
// Assertion macros for the WebSocket frame deframer.
// Used by the top level only; needs a clk and rst in scope.
`ifndef WEBSOCKET_CLIENT_FRAME_DEFRAMER_DEFINES_SVH
`define WEBSOCKET_CLIENT_FRAME_DEFRAMER_DEFINES_SVH
`ifndef ASSERT_OFF
// Condition must hold at every clock edge out of reset
`define WSD_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// Antecedent implies consequent in the same cycle
`define WSD_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define WSD_ASSERT_ALWAYS(lbl, cond, msg)
`define WSD_ASSERT_IMPLY(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/wsdefr_pkg.sv =====
// Shared types and constants for the WebSocket frame deframer.
// No dependencies.
package wsdefr_pkg;

  // Result kinds
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_EMPTY   = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  // Error codes, in check order
  localparam logic [3:0] ERR_RSV          = 4'd0;
  localparam logic [3:0] ERR_OPCODE       = 4'd1;
  localparam logic [3:0] ERR_FRAG_DATA    = 4'd2;
  localparam logic [3:0] ERR_CONTINUATION = 4'd3;
  localparam logic [3:0] ERR_UNMASKED     = 4'd4;
  localparam logic [3:0] ERR_NONMIN16     = 4'd5;
  localparam logic [3:0] ERR_BIT63        = 4'd6;
  localparam logic [3:0] ERR_NONMIN64     = 4'd7;
  localparam logic [3:0] ERR_FRAG_CTRL    = 4'd8;
  localparam logic [3:0] ERR_CTRL_LONG    = 4'd9;
  localparam logic [3:0] ERR_CLOSE_ONE    = 4'd10;

  // Opcodes
  localparam logic [3:0] OPC_CONT  = 4'h0;
  localparam logic [3:0] OPC_TEXT  = 4'h1;
  localparam logic [3:0] OPC_BIN   = 4'h2;
  localparam logic [3:0] OPC_CLOSE = 4'h8;
  localparam logic [3:0] OPC_PING  = 4'h9;
  localparam logic [3:0] OPC_PONG  = 4'hA;

  // Length field markers and limits
  localparam logic [6:0]  LEN7_EXT16   = 7'd126;
  localparam logic [6:0]  LEN7_EXT64   = 7'd127;
  localparam logic [63:0] MIN_LEN16    = 64'd126;
  localparam logic [63:0] MIN_LEN64    = 64'd65536;
  localparam logic [63:0] CTRL_MAX_LEN = 64'd125;

  // One result word
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [3:0]  frame_opcode;
    logic        final_flag;
    logic [62:0] frame_length;
    logic [3:0]  error_code;
    logic        last;
  } res_t;

endpackage

// ===== rtl/wsdefr_parser.sv =====
// Frame parser: header, extended length, mask key and payload unmasking.
// One byte per accepted word; depends on wsdefr_pkg.
module wsdefr_parser import wsdefr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic       op,
  input  logic [7:0] data_byte,
  output logic       res_valid,
  output res_t       res
);

  localparam logic [2:0] PH_HDR0    = 3'd0;
  localparam logic [2:0] PH_HDR1    = 3'd1;
  localparam logic [2:0] PH_EXT16   = 3'd2;
  localparam logic [2:0] PH_EXT64   = 3'd3;
  localparam logic [2:0] PH_MASK    = 3'd4;
  localparam logic [2:0] PH_PAYLOAD = 3'd5;
  localparam logic [2:0] PH_HALT    = 3'd6;

  logic [2:0]  phase, phase_next;
  logic        held_fin, held_fin_next;
  logic [3:0]  held_opcode, held_opcode_next;
  logic [63:0] len_acc, len_acc_next;
  logic [2:0]  ext_cnt, ext_cnt_next;
  logic [31:0] mask_key, mask_key_next;
  logic [1:0]  mask_index, mask_index_next;
  logic [62:0] pay_rem, pay_rem_next;

  logic [63:0] acc_shift;
  logic [62:0] rem_dec;
  logic [7:0]  key_byte;
  logic [4:0]  len_chk;
  logic        err;
  logic [3:0]  err_code;

  function automatic logic opc_valid(input logic [3:0] opc);
    return (opc == OPC_CONT) || (opc == OPC_TEXT) || (opc == OPC_BIN) ||
           (opc == OPC_CLOSE) || (opc == OPC_PING) || (opc == OPC_PONG);
  endfunction

  // {error found, code} for the checks run once the length is known
  function automatic logic [4:0] length_check(input logic [3:0] opc, input logic fin,
                                              input logic [63:0] acc);
    logic [4:0] r;
    r = '0;
    if (opc[3] && !fin) begin
      r = {1'b1, ERR_FRAG_CTRL};
    end else if (opc[3] && (acc > CTRL_MAX_LEN)) begin
      r = {1'b1, ERR_CTRL_LONG};
    end else if ((opc == OPC_CLOSE) && (acc == 64'd1)) begin
      r = {1'b1, ERR_CLOSE_ONE};
    end
    return r;
  endfunction

  assign acc_shift = {len_acc[55:0], data_byte};
  assign rem_dec   = pay_rem - 63'd1;

  // Key byte for this payload position, most significant first
  always_comb begin
    case (mask_index)
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
  end

  // Next state and result for the accepted word
  always_comb begin
    phase_next       = phase;
    held_fin_next    = held_fin;
    held_opcode_next = held_opcode;
    len_acc_next     = len_acc;
    ext_cnt_next     = ext_cnt;
    mask_key_next    = mask_key;
    mask_index_next  = mask_index;
    pay_rem_next     = pay_rem;
    res_valid        = 1'b0;
    res              = '0;
    res.kind         = KIND_PAYLOAD;
    err              = 1'b0;
    err_code         = ERR_RSV;
    len_chk          = '0;

    if (accept && op) begin
      phase_next       = PH_HDR0;
      held_fin_next    = 1'b0;
      held_opcode_next = OPC_CONT;
      len_acc_next     = '0;
      ext_cnt_next     = '0;
      mask_key_next    = '0;
      mask_index_next  = '0;
      pay_rem_next     = '0;
    end else if (accept) begin
      case (phase)
        PH_HDR0: begin
          held_fin_next    = data_byte[7];
          held_opcode_next = data_byte[3:0];
          len_acc_next     = '0;
          ext_cnt_next     = '0;
          mask_key_next    = '0;
          mask_index_next  = '0;
          pay_rem_next     = '0;
          phase_next       = PH_HDR1;
          if (data_byte[6:4] != 3'd0) begin
            err = 1'b1; err_code = ERR_RSV;
          end else if (!opc_valid(data_byte[3:0])) begin
            err = 1'b1; err_code = ERR_OPCODE;
          end else if (!data_byte[7] && !data_byte[3]) begin
            err = 1'b1; err_code = ERR_FRAG_DATA;
          end else if (data_byte[3:0] == OPC_CONT) begin
            err = 1'b1; err_code = ERR_CONTINUATION;
          end
        end
        PH_HDR1: begin
          ext_cnt_next = '0;
          if (!data_byte[7]) begin
            err = 1'b1; err_code = ERR_UNMASKED;
          end else if (data_byte[6:0] == LEN7_EXT16) begin
            phase_next = PH_EXT16;
          end else if (data_byte[6:0] == LEN7_EXT64) begin
            phase_next = PH_EXT64;
          end else begin
            len_acc_next    = {57'd0, data_byte[6:0]};
            len_chk         = length_check(held_opcode, held_fin, len_acc_next);
            err             = len_chk[4];
            err_code        = len_chk[3:0];
            phase_next      = PH_MASK;
            mask_index_next = '0;
          end
        end
        PH_EXT16: begin
          len_acc_next = acc_shift;
          if (ext_cnt >= 3'd1) begin
            ext_cnt_next    = '0;
            len_chk         = length_check(held_opcode, held_fin, acc_shift);
            phase_next      = PH_MASK;
            mask_index_next = '0;
            if (acc_shift < MIN_LEN16) begin
              err = 1'b1; err_code = ERR_NONMIN16;
            end else begin
              err = len_chk[4]; err_code = len_chk[3:0];
            end
          end else begin
            ext_cnt_next = ext_cnt + 3'd1;
          end
        end
        PH_EXT64: begin
          len_acc_next = acc_shift;
          if (ext_cnt >= 3'd7) begin
            ext_cnt_next    = '0;
            len_chk         = length_check(held_opcode, held_fin, acc_shift);
            phase_next      = PH_MASK;
            mask_index_next = '0;
            if (acc_shift[63]) begin
              err = 1'b1; err_code = ERR_BIT63;
            end else if (acc_shift < MIN_LEN64) begin
              err = 1'b1; err_code = ERR_NONMIN64;
            end else begin
              err = len_chk[4]; err_code = len_chk[3:0];
            end
          end else begin
            ext_cnt_next = ext_cnt + 3'd1;
          end
        end
        PH_MASK: begin
          mask_key_next = {mask_key[23:0], data_byte};
          if (mask_index == 2'd3) begin
            mask_index_next = '0;
            pay_rem_next    = len_acc[62:0];
            if (len_acc[62:0] == 63'd0) begin
              phase_next = PH_HDR0;
              res_valid  = 1'b1;
              res.kind   = KIND_EMPTY;
              res.last   = 1'b1;
            end else begin
              phase_next = PH_PAYLOAD;
            end
          end else begin
            mask_index_next = mask_index + 2'd1;
          end
        end
        PH_PAYLOAD: begin
          mask_index_next  = mask_index + 2'd1;
          pay_rem_next     = rem_dec;
          res_valid        = 1'b1;
          res.kind         = KIND_PAYLOAD;
          res.payload_byte = data_byte ^ key_byte;
          if (rem_dec == 63'd0) begin
            phase_next = PH_HDR0;
            res.last   = 1'b1;
          end
        end
        default: begin
          // halted: bytes are dropped until a restart
        end
      endcase

      // An error halts the parser and reports once
      if (err) begin
        phase_next     = PH_HALT;
        res_valid      = 1'b1;
        res.kind       = KIND_ERROR;
        res.error_code = err_code;
        res.last       = 1'b1;
      end
    end

    // Frame fields show the state as updated by this word
    res.frame_opcode = held_opcode_next;
    res.final_flag   = held_fin_next;
    res.frame_length = len_acc_next[62:0];
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HDR0;
      held_fin    <= 1'b0;
      held_opcode <= OPC_CONT;
      len_acc     <= '0;
      ext_cnt     <= '0;
      mask_key    <= '0;
      mask_index  <= '0;
      pay_rem     <= '0;
    end else begin
      phase       <= phase_next;
      held_fin    <= held_fin_next;
      held_opcode <= held_opcode_next;
      len_acc     <= len_acc_next;
      ext_cnt     <= ext_cnt_next;
      mask_key    <= mask_key_next;
      mask_index  <= mask_index_next;
      pay_rem     <= pay_rem_next;
    end
  end

endmodule

// ===== rtl/wsdefr_outreg.sv =====
// Result register holding one word until the receiver takes it.
// Depends on wsdefr_pkg.
module wsdefr_outreg import wsdefr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic load,
  input  res_t load_res,
  input  logic stall,
  output logic valid,
  output res_t res
);

  // Valid flag: set on load, cleared when the word leaves
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (!stall) begin
      valid <= 1'b0;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (load) begin
      res <= load_res;
    end
  end

endmodule

// ===== rtl/websocket_client_frame_deframer.sv =====
// Top level of the WebSocket client-to-server frame deframer.
// Uses wsdefr_pkg, wsdefr_parser, wsdefr_outreg and the assertion header.
//
// Takes one stream byte (or a restart) per cycle and gives at most one
// result word per byte: an unmasked payload byte, an empty-frame marker or
// an error. Throughput is one byte per clock with no bubbles; a byte is
// parsed in the cycle it is accepted and its result appears from the result
// register on the next cycle. The only thing that holds the input back is a
// full result register whose word the receiver is stalling. After an error
// the block swallows bytes without results until a restart word (op = 1).
`include "websocket_client_frame_deframer_defines.svh"
module websocket_client_frame_deframer import wsdefr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic        op,
  input  logic [7:0]  data_byte,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  kind,
  output logic [7:0]  payload_byte,
  output logic [3:0]  frame_opcode,
  output logic        final_flag,
  output logic [62:0] frame_length,
  output logic [3:0]  error_code,
  output logic        last
);

  logic accept;
  logic res_valid;
  res_t res_word;
  res_t out_word;

  // Input waits only while the result register is full and stalled
  assign item_stall = result_valid & result_stall;
  assign accept     = item_valid & ~item_stall;

  wsdefr_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .op        (op),
    .data_byte (data_byte),
    .res_valid (res_valid),
    .res       (res_word)
  );

  wsdefr_outreg u_outreg (
    .clk      (clk),
    .rst      (rst),
    .load     (res_valid),
    .load_res (res_word),
    .stall    (result_stall),
    .valid    (result_valid),
    .res      (out_word)
  );

  assign kind         = out_word.kind;
  assign payload_byte = out_word.payload_byte;
  assign frame_opcode = out_word.frame_opcode;
  assign final_flag   = out_word.final_flag;
  assign frame_length = out_word.frame_length;
  assign error_code   = out_word.error_code;
  assign last         = out_word.last;

  // Checks
  `WSD_ASSERT_IMPLY(a_stall_needs_word, item_stall, result_valid, "input stalled with no word held")
  `WSD_ASSERT_IMPLY(a_error_is_last, result_valid && (kind == KIND_ERROR), last, "error without last")
  `WSD_ASSERT_IMPLY(a_kind_known, result_valid, (kind == KIND_PAYLOAD) || (kind == KIND_EMPTY) || (kind == KIND_ERROR), "bad result kind")
  `WSD_ASSERT_IMPLY(a_empty_is_last, result_valid && (kind == KIND_EMPTY), last && (frame_length == 63'd0), "empty frame marker malformed")

endmodule

// ===== tb/websocket_client_frame_deframer_checker.sv =====
// Checker for the WebSocket frame deframer: watches both channels, decodes each accepted
// word into the result it must cause and compares the result stream field by field.
// Depends on wsdefr_pkg.
module websocket_client_frame_deframer_checker import wsdefr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  input  logic        item_stall,
  input  logic        op,
  input  logic [7:0]  data_byte,
  input  logic        result_valid,
  input  logic        result_stall,
  input  logic [1:0]  kind,
  input  logic [7:0]  payload_byte,
  input  logic [3:0]  frame_opcode,
  input  logic        final_flag,
  input  logic [62:0] frame_length,
  input  logic [3:0]  error_code,
  input  logic        last,
  output int          pending,
  output int          fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    PH_HDR0, PH_HDR1, PH_EXT16, PH_EXT64, PH_MASK, PH_PAYLOAD, PH_HALT
  } parse_phase_t;

  // Shadow parser state
  parse_phase_t ph;
  logic         fin_q;
  logic [3:0]   opc_q;
  logic [63:0]  len_acc;
  logic [2:0]   ext_cnt;
  logic [31:0]  key_q;
  logic [1:0]   key_idx;
  logic [62:0]  remain;

  res_t frame_results_q[$];
  int   n_fail = 0;

  assign fail_count = n_fail;

  function automatic void clear_state();
    ph      = PH_HDR0;
    fin_q   = 1'b0;
    opc_q   = '0;
    len_acc = '0;
    ext_cnt = '0;
    key_q   = '0;
    key_idx = '0;
    remain  = '0;
  endfunction

  function automatic res_t result_word(input logic [1:0] k, input logic [7:0] pb,
                                       input logic [3:0] code, input logic lst);
    res_t r;
    r.kind         = k;
    r.payload_byte = pb;
    r.frame_opcode = opc_q;
    r.final_flag   = fin_q;
    r.frame_length = len_acc[62:0];
    r.error_code   = code;
    r.last         = lst;
    return r;
  endfunction

  // Control-frame and close rules, applied once the length is known
  function automatic bit length_rule_broken(output logic [3:0] code);
    code = '0;
    if (opc_q >= OPC_CLOSE && !fin_q) begin
      code = ERR_FRAG_CTRL;
      return 1'b1;
    end
    if (opc_q >= OPC_CLOSE && len_acc > CTRL_MAX_LEN) begin
      code = ERR_CTRL_LONG;
      return 1'b1;
    end
    if (opc_q == OPC_CLOSE && len_acc == 64'd1) begin
      code = ERR_CLOSE_ONE;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Advance the shadow parser by one word; returns 1 when a result is due
  function automatic bit decode_word(input logic o, input logic [7:0] b, output res_t r);
    bit         bad;
    bit         hit;
    logic [3:0] code;
    logic [7:0] kb;
    bad  = 1'b0;
    hit  = 1'b0;
    code = '0;
    r    = '0;
    if (o) begin
      clear_state();
      return 1'b0;
    end
    case (ph)
      PH_HDR0: begin
        fin_q   = b[7];
        opc_q   = b[3:0];
        len_acc = '0;
        ext_cnt = '0;
        key_q   = '0;
        key_idx = '0;
        remain  = '0;
        if (b[6:4] != 3'b000) begin
          bad = 1'b1; code = ERR_RSV;
        end else if (!(opc_q inside {OPC_CONT, OPC_TEXT, OPC_BIN,
                                      OPC_CLOSE, OPC_PING, OPC_PONG})) begin
          bad = 1'b1; code = ERR_OPCODE;
        end else if (!fin_q && opc_q < OPC_CLOSE) begin
          bad = 1'b1; code = ERR_FRAG_DATA;
        end else if (opc_q == OPC_CONT) begin
          bad = 1'b1; code = ERR_CONTINUATION;
        end else begin
          ph = PH_HDR1;
        end
      end
      PH_HDR1: begin
        ext_cnt = '0;
        if (!b[7]) begin
          bad = 1'b1; code = ERR_UNMASKED;
        end else if (b[6:0] == LEN7_EXT16) begin
          ph = PH_EXT16;
        end else if (b[6:0] == LEN7_EXT64) begin
          ph = PH_EXT64;
        end else begin
          len_acc = {57'd0, b[6:0]};
          bad = length_rule_broken(code);
          if (!bad) begin ph = PH_MASK; key_idx = '0; end
        end
      end
      PH_EXT16: begin
        len_acc = {len_acc[55:0], b};
        if (ext_cnt >= 3'd1) begin
          ext_cnt = '0;
          if (len_acc < MIN_LEN16) begin
            bad = 1'b1; code = ERR_NONMIN16;
          end else begin
            bad = length_rule_broken(code);
            if (!bad) begin ph = PH_MASK; key_idx = '0; end
          end
        end else begin
          ext_cnt = ext_cnt + 3'd1;
        end
      end
      PH_EXT64: begin
        len_acc = {len_acc[55:0], b};
        if (ext_cnt >= 3'd7) begin
          ext_cnt = '0;
          if (len_acc[63]) begin
            bad = 1'b1; code = ERR_BIT63;
          end else if (len_acc < MIN_LEN64) begin
            bad = 1'b1; code = ERR_NONMIN64;
          end else begin
            bad = length_rule_broken(code);
            if (!bad) begin ph = PH_MASK; key_idx = '0; end
          end
        end else begin
          ext_cnt = ext_cnt + 3'd1;
        end
      end
      PH_MASK: begin
        key_q = {key_q[23:0], b};
        if (key_idx == 2'd3) begin
          key_idx = '0;
          remain  = len_acc[62:0];
          if (remain == '0) begin
            ph  = PH_HDR0;
            r   = result_word(KIND_EMPTY, 8'd0, '0, 1'b1);
            hit = 1'b1;
          end else begin
            ph = PH_PAYLOAD;
          end
        end else begin
          key_idx = key_idx + 2'd1;
        end
      end
      PH_PAYLOAD: begin
        // key byte 0 sits in the top byte of the key register
        kb      = 8'(key_q >> {~key_idx, 3'b000});
        key_idx = key_idx + 2'd1;
        remain  = remain - 63'd1;
        if (remain == '0) ph = PH_HDR0;
        r   = result_word(KIND_PAYLOAD, b ^ kb, '0, remain == '0);
        hit = 1'b1;
      end
      default: ;  // halted: swallow until restart
    endcase
    if (bad) begin
      ph  = PH_HALT;
      r   = result_word(KIND_ERROR, 8'd0, code, 1'b1);
      hit = 1'b1;
    end
    return hit;
  endfunction

  task automatic check_field(input string name, input logic [62:0] want,
                             input logic [62:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_fail++;
    end
  endtask

  // Compare the result word first, then queue what the new word causes
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      clear_state();
      frame_results_q.delete();
    end else begin
      if (result_valid && !result_stall) begin
        if (frame_results_q.size() == 0) begin
          $error("unexpected result word: kind %0h, payload_byte %0h", kind, payload_byte);
          n_fail++;
        end else begin
          want = frame_results_q.pop_front();
          check_field("kind", 63'(want.kind), 63'(kind));
          check_field("payload_byte", 63'(want.payload_byte), 63'(payload_byte));
          check_field("frame_opcode", 63'(want.frame_opcode), 63'(frame_opcode));
          check_field("final_flag", 63'(want.final_flag), 63'(final_flag));
          check_field("frame_length", want.frame_length, frame_length);
          check_field("error_code", 63'(want.error_code), 63'(error_code));
          check_field("last", 63'(want.last), 63'(last));
        end
      end
      if (item_valid && !item_stall) begin
        if (decode_word(op, data_byte, want)) frame_results_q.push_back(want);
      end
    end
    pending <= frame_results_q.size();
  end

  final begin
    if (frame_results_q.size() != 0)
      $error("%0d result words never arrived", frame_results_q.size());
  end
endmodule

// ===== tb/websocket_client_frame_deframer_tb.sv =====
// Top of the WebSocket frame deframer testbench: clock, reset, word stimulus and verdict.
// Depends on wsdefr_pkg, websocket_client_frame_deframer and its checker module.
module websocket_client_frame_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wsdefr_pkg::*;

  localparam int RANDOM_WORDS = 800;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        item_valid   = 1'b0;
  logic        op           = 1'b0;
  logic [7:0]  data_byte    = 8'd0;
  logic        result_stall = 1'b0;
  logic        item_stall;
  logic        result_valid;
  logic [1:0]  kind;
  logic [7:0]  payload_byte;
  logic [3:0]  frame_opcode;
  logic        final_flag;
  logic [62:0] frame_length;
  logic [3:0]  error_code;
  logic        last;
  int          pending;
  int          fail_count;

  bit quiet        = 1'b0;
  int sent_words   = 0;
  int halted_words = 0;

  websocket_client_frame_deframer dut (
    .clk, .rst, .item_valid, .item_stall, .op, .data_byte,
    .result_valid, .result_stall, .kind, .payload_byte, .frame_opcode,
    .final_flag, .frame_length, .error_code, .last
  );

  websocket_client_frame_deframer_checker checker_i (
    .clk, .rst, .item_valid, .item_stall, .op, .data_byte,
    .result_valid, .result_stall, .kind, .payload_byte, .frame_opcode,
    .final_flag, .frame_length, .error_code, .last, .pending, .fail_count
  );

  always #5 clk = ~clk;

  // Receiver stalls at random except in the quiet stretch
  always @(posedge clk) begin
    result_stall <= !quiet && ($urandom_range(99) < 31);
  end

  // Offer one word after a random idle gap; returns at the edge that accepts it
  task automatic put_word(input logic o, input logic [7:0] b);
    while (!quiet && $urandom_range(99) < 31) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    op         <= o;
    data_byte  <= b;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sent_words++;
  endtask

  task automatic put_byte(input logic [7:0] b);
    put_word(1'b0, b);
  endtask

  task automatic restart();
    put_word(1'b1, 8'($urandom));
  endtask

  // Minimal length encoding
  task automatic send_header(input logic fin, input logic [3:0] opc, input logic [63:0] len);
    put_byte({fin, 3'b000, opc});
    if (len < MIN_LEN16) begin
      put_byte({1'b1, len[6:0]});
    end else if (len < MIN_LEN64) begin
      put_byte({1'b1, LEN7_EXT16});
      put_byte(len[15:8]);
      put_byte(len[7:0]);
    end else begin
      put_byte({1'b1, LEN7_EXT64});
      for (int i = 7; i >= 0; i--) put_byte(len[8*i +: 8]);
    end
  endtask

  task automatic send_body(input int n);
    repeat (4) put_byte(8'($urandom));
    repeat (n) put_byte(8'($urandom));
  endtask

  // Hold the sender until every queued result has arrived
  task automatic drain();
    item_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    int          pick;
    int          sel;
    int          frames;
    int          base;
    logic [3:0]  opc;
    logic [63:0] len;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: restart, empty ping, byte extremes, close of length one, reserved bits
    restart();
    put_byte({1'b1, 3'b000, OPC_PING});
    put_byte(8'h80);
    repeat (4) put_byte(8'h00);
    put_byte({1'b1, 3'b000, OPC_BIN});
    put_byte(8'h82);
    repeat (4) put_byte(8'hFF);
    put_byte(8'h00);
    put_byte(8'hFF);
    put_byte({1'b1, 3'b000, OPC_CLOSE});
    put_byte(8'h81);
    put_byte(8'h00);
    restart();
    put_byte({1'b1, 3'b111, OPC_TEXT});
    restart();
    drain();

    // Random frames: mostly well formed, the rest cut short, broken or noise
    base   = sent_words;
    frames = 0;
    while (sent_words - halted_words - base < RANDOM_WORDS) begin
      // quiet stretch in the middle of the run, by word count
      quiet = (sent_words - base >= 250) && (sent_words - base < 450);
      if (frames % 25 == 24) drain();
      pick = $urandom_range(99);
      if (pick < 62) begin
        // well-formed frame
        if ($urandom_range(1)) begin
          opc = OPC_CLOSE + 4'($urandom_range(2));
          len = 64'($urandom_range(0, ($urandom_range(9) == 0) ? 125 : 6));
          if (opc == OPC_CLOSE && len == 64'd1) len = 64'd2;
        end else begin
          opc = OPC_TEXT + 4'($urandom_range(1));
          sel = $urandom_range(19);
          len = (sel == 0) ? 64'($urandom_range(126, 300)) :
                (sel == 1) ? 64'($urandom_range(13, 125)) : 64'($urandom_range(0, 12));
        end
        send_header(1'b1, opc, len);
        send_body(int'(len));
      end else if (pick < 68) begin
        // long frame cut short by a restart
        sel = $urandom_range(3);
        case (sel)
          0:       len = 64'($urandom_range(300, 65535));
          1:       len = MIN_LEN64;
          2:       len = 64'h7FFF_FFFF_FFFF_FFFF;
          default: begin
            len = {1'b0, 31'($urandom), 32'($urandom)};
            if (len < MIN_LEN64) len = len | MIN_LEN64;
          end
        endcase
        send_header(1'b1, OPC_TEXT + 4'($urandom_range(1)), len);
        send_body($urandom_range(0, 12));
        restart();
      end else if (pick < 93) begin
        // header that breaks one rule, then swallowed bytes and a restart
        sel = $urandom_range(10);
        case (sel)
          0: put_byte({1'($urandom), 3'($urandom_range(1, 7)), 4'($urandom)});
          1: begin
            sel = $urandom_range(9);
            opc = (sel < 5) ? OPC_BIN + 4'(1 + sel) : OPC_PONG + 4'(sel - 4);
            put_byte({1'($urandom), 3'b000, opc});
          end
          2: put_byte({1'b0, 3'b000, OPC_TEXT + 4'($urandom_range(1))});
          3: put_byte({1'b1, 3'b000, OPC_CONT});
          4: begin
            put_byte({1'b1, 3'b000, OPC_BIN});
            put_byte({1'b0, 7'($urandom)});
          end
          5: begin
            put_byte({1'b1, 3'b000, OPC_TEXT});
            put_byte({1'b1, LEN7_EXT16});
            put_byte(8'h00);
            put_byte(8'($urandom_range(0, 125)));
          end
          6: begin
            put_byte({1'b1, 3'b000, OPC_BIN});
            put_byte({1'b1, LEN7_EXT64});
            put_byte(8'($urandom_range(128, 255)));
            repeat (7) put_byte(8'($urandom));
          end
          7: begin
            put_byte({1'b1, 3'b000, OPC_TEXT});
            put_byte({1'b1, LEN7_EXT64});
            repeat (6) put_byte(8'h00);
            repeat (2) put_byte(8'($urandom));
          end
          8: begin
            put_byte({1'b0, 3'b000, OPC_CLOSE + 4'($urandom_range(2))});
            put_byte({1'b1, 7'($urandom_range(0, 125))});
          end
          9: begin
            put_byte({1'b1, 3'b000, OPC_CLOSE + 4'($urandom_range(2))});
            put_byte({1'b1, LEN7_EXT16});
            len = 64'($urandom_range(126, 65535));
            put_byte(len[15:8]);
            put_byte(len[7:0]);
          end
          default: begin
            put_byte({1'b1, 3'b000, OPC_CLOSE});
            put_byte(8'h81);
          end
        endcase
        repeat ($urandom_range(0, 3)) begin
          put_byte(8'($urandom));
          halted_words++;
        end
        restart();
      end else begin
        // raw noise, then a restart
        repeat ($urandom_range(1, 8)) put_byte(8'($urandom));
        restart();
      end
      if ($urandom_range(19) == 0) restart();
      frames++;
    end
    quiet = 1'b0;
    item_valid <= 1'b0;

    // Let every result come home, then wait out any stragglers
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("** websocket_client_frame_deframer: PASSED **");
    end else begin
      $display("** websocket_client_frame_deframer: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("** websocket_client_frame_deframer: FAILED **");
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/wsdefr_pkg.sv
rtl/wsdefr_parser.sv
rtl/wsdefr_outreg.sv
rtl/websocket_client_frame_deframer.sv
tb/websocket_client_frame_deframer_checker.sv
tb/websocket_client_frame_deframer_tb.sv
